// File: rtl/ahfe_pkg.sv
// shared types, constants and helper functions for the ascii hex frame encoder
package ahfe_pkg;

    localparam logic [7:0]  START_CHAR = 8'h02;
    localparam logic [7:0]  END_CHAR   = 8'h03;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // character slots of one command, sent lowest first
    localparam int SLOT_START  = 0;
    localparam int SLOT_DATA_H = 1;
    localparam int SLOT_DATA_L = 2;
    localparam int SLOT_CRC0_H = 3;
    localparam int SLOT_CRC0_L = 4;
    localparam int SLOT_CRC1_H = 5;
    localparam int SLOT_CRC1_L = 6;
    localparam int SLOT_END    = 7;
    localparam int NSLOTS      = 8;

    typedef struct packed {
        logic [NSLOTS-1:0] mask;
        logic [7:0]        data;
        logic [15:0]       crc;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        return (nib <= 4'd9) ? wide + 8'd48 : wide + 8'd55;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  x;
        logic [15:0] xw;
        x  = crc[15:8] ^ b;
        x  = x ^ (x >> 4);
        xw = {8'h00, x};
        return (crc << 8) ^ (xw << 12) ^ (xw << 5) ^ xw;
    endfunction

endpackage

// File: rtl/ascii_hex_frame_encoder_crc16_core.sv
// top level: ascii hex frame encoder with crc-16, front, queue and back joined
// the first character of a beat passes through the queue, the back slot mask and the output register to m_valid
// throughput: one character per cycle from the back sequencer while m_ready is high, so a
// payload beat gives 2 characters, a beat that opens a frame 3, a closing beat up to 8
// reset: synchronous active low aresetn clears the queue, output valid and frame state;
// crc returns to 0xFFFF and no frame is open
module ascii_hex_frame_encoder_crc16_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       s_empty_frame,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_run_last,
    output logic       m_frame_end
);
    import ahfe_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push, full, pop, empty;

    ahfe_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .s_empty_frame (s_empty_frame),
        .q_push        (push),
        .q_cmd         (push_cmd),
        .q_full        (full)
    );

    ahfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    ahfe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_cmd       (pop_cmd),
        .q_empty     (empty),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

endmodule

// File: rtl/ahfe_front.sv
// front end: accepts beats, tracks the open frame and crc, builds character commands
module ahfe_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_data_byte,
    input  logic          s_last_byte,
    input  logic          s_empty_frame,
    output logic          q_push,
    output ahfe_pkg::cmd_t q_cmd,
    input  logic          q_full
);
    import ahfe_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] crc_base, crc_after;
    logic        close;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign close   = s_empty_frame || s_last_byte;

    always_comb begin
        crc_base  = in_frame_reg ? crc_reg : CRC_INIT;
        crc_after = s_empty_frame ? crc_base : crc_update(crc_base, s_data_byte);

        q_cmd.mask              = '0;
        q_cmd.mask[SLOT_START]  = !in_frame_reg;
        q_cmd.mask[SLOT_DATA_H] = !s_empty_frame;
        q_cmd.mask[SLOT_DATA_L] = !s_empty_frame;
        q_cmd.mask[SLOT_CRC0_H] = close;
        q_cmd.mask[SLOT_CRC0_L] = close;
        q_cmd.mask[SLOT_CRC1_H] = close;
        q_cmd.mask[SLOT_CRC1_L] = close;
        q_cmd.mask[SLOT_END]    = close;
        q_cmd.data              = s_data_byte;
        q_cmd.crc               = crc_after;

        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (q_push) begin
            crc_next      = close ? CRC_INIT : crc_after;
            in_frame_next = !close;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_INIT;
            in_frame_reg <= 1'b0;
        end else begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// File: rtl/ahfe_queue.sv
// short command queue between front and back
module ahfe_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ahfe_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output ahfe_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import ahfe_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/ahfe_back.sv
// back end: walks the character slots of each command, one character per cycle unless m_ready stalls the output
module ahfe_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  ahfe_pkg::cmd_t q_cmd,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_char,
    output logic           m_run_last,
    output logic           m_frame_end
);
    import ahfe_pkg::*;

    logic [NSLOTS-1:0] mask_reg, mask_next;
    logic [7:0]        data_reg;
    logic [15:0]       crc_reg;
    logic              valid_reg, valid_next;
    logic [7:0]        char_reg;
    logic              run_last_reg;
    logic              frame_end_reg;

    logic [NSLOTS-1:0] sel, rem;
    logic              emit;
    logic [7:0]        char_sel;

    assign sel   = mask_reg & (~mask_reg + 1'b1);
    assign rem   = mask_reg & ~sel;
    assign emit  = (mask_reg != '0) && (!valid_reg || m_ready);
    assign q_pop = !q_empty && ((mask_reg == '0) || (emit && rem == '0));

    always_comb begin
        priority if (sel[SLOT_START]) begin
            char_sel = START_CHAR;
        end else if (sel[SLOT_DATA_H]) begin
            char_sel = hex_char(data_reg[7:4]);
        end else if (sel[SLOT_DATA_L]) begin
            char_sel = hex_char(data_reg[3:0]);
        end else if (sel[SLOT_CRC0_H]) begin
            char_sel = hex_char(crc_reg[7:4]);
        end else if (sel[SLOT_CRC0_L]) begin
            char_sel = hex_char(crc_reg[3:0]);
        end else if (sel[SLOT_CRC1_H]) begin
            char_sel = hex_char(crc_reg[15:12]);
        end else if (sel[SLOT_CRC1_L]) begin
            char_sel = hex_char(crc_reg[11:8]);
        end else begin
            char_sel = END_CHAR;
        end
    end

    always_comb begin
        mask_next = mask_reg;
        if (q_pop) begin
            mask_next = q_cmd.mask;
        end else if (emit) begin
            mask_next = rem;
        end
        valid_next = valid_reg;
        if (emit) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    // payload and output character registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_cmd.data;
            crc_reg  <= q_cmd.crc;
        end
        if (emit) begin
            char_reg      <= char_sel;
            run_last_reg  <= (rem == '0);
            frame_end_reg <= sel[SLOT_END];
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_char  = char_reg;
    assign m_run_last  = run_last_reg;
    assign m_frame_end = frame_end_reg;

endmodule
